// ----- sv/pli_pkg.sv -----
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

  localparam int unsigned MaxPoints  = 64;
  localparam int unsigned IdxW       = $clog2(MaxPoints);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned ValW       = 32;
  localparam int unsigned ProdW      = 2 * ValW;
  localparam int unsigned SumW       = ProdW + 1;
  localparam int unsigned StatW      = 3;
  localparam int unsigned PaddrW     = 3;
  localparam logic [PaddrW-1:0] AddrPointsInUse = 3'd0;
  localparam logic [CntW-1:0]   PointsReset     = CntW'(2);

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  localparam logic [StatW-1:0] StInterp  = 3'd0;
  localparam logic [StatW-1:0] StClampLo = 3'd1;
  localparam logic [StatW-1:0] StClampHi = 3'd2;
  localparam logic [StatW-1:0] StSat     = 3'd3;
  localparam logic [StatW-1:0] StZeroSeg = 3'd4;

  typedef struct packed {
    logic                   opcode;
    logic [IdxW-1:0]        point_index;
    logic signed [ValW-1:0] x_value;
    logic signed [ValW-1:0] y_value;
  } in_word_t;

  typedef struct packed {
    logic signed [ValW-1:0] y_out;
    logic [StatW-1:0]       status;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic            capture;   // latch the incoming word
    logic            load;      // write the table at the captured slot
    logic            rd_en;     // issue a table read
    logic [IdxW-1:0] rd_addr;
    logic            chk_lo;    // read data holds slot 0
    logic            chk_hi;    // read data holds last slot
    logic            chk_seg;   // read data holds slot k+1, previous holds k
    logic            keep_prev; // keep read data as x_k / y_k
    logic            mul_a;     // first product
    logic            mul_b;     // second product
    logic            sum;       // combine products, start divide
    logic            div_step;
    logic            out_clamp_lo;
    logic            out_clamp_hi;
    logic            out_zero;
    logic            out_div;
  } pli_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic below;      // x < x_0
    logic above;      // x >= x_last
    logic in_seg;     // x_k <= x < x_k+1
    logic div_done;
  } pli_sts_t;

endpackage

// ----- sv/piecewise_linear_interpolator.sv -----
// Top level: APB register, input and output channels, controller and datapath.
// A load word is captured and then written to the table. An evaluate word reads
// slot 0 and clamps low, or reads the last slot and clamps high, or else searches
// the segments in turn (a zero-segment result if none holds x), forms and combines
// two products and runs the divider (one quotient bit a cycle) before the result
// is presented. The segment search reads the breakpoint memory slot by slot
// through its single registered port. A new word is accepted only once the previous result has been taken.
module piecewise_linear_interpolator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pli_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pli_pkg::out_word_t         out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pli_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pli_pkg::*;

  logic [CntW-1:0] npts_q;
  pli_cmd_t        cmd;
  pli_sts_t        sts;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      npts_q <= PointsReset;
    end else if (psel && penable && pwrite && paddr == AddrPointsInUse) begin
      npts_q <= pwdata[CntW-1:0];
    end
  end
  assign prdata = (paddr == AddrPointsInUse) ? {{(32-CntW){1'b0}}, npts_q} : '0;

  pli_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_opcode_i(in_word_i.opcode),
    .out_valid_o, .out_stall_i,
    .npts_i(npts_q), .sts_i(sts), .cmd_o(cmd)
  );

  pli_datapath u_dp (
    .clk_i, .rst_ni, .in_word_i, .cmd_i(cmd), .sts_o(sts), .res_o(out_word_o)
  );

endmodule

// ----- sv/pli_datapath.sv -----
// Datapath: breakpoint memory, compares, multiplier and restoring divider.
module pli_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pli_pkg::in_word_t  in_word_i,
  input  pli_pkg::pli_cmd_t  cmd_i,
  output pli_pkg::pli_sts_t  sts_o,
  output pli_pkg::out_word_t res_o
);
  import pli_pkg::*;

  logic signed [ValW-1:0] mem_x [MaxPoints];
  logic signed [ValW-1:0] mem_y [MaxPoints];
  logic signed [ValW-1:0] rx_q, ry_q, xk_q, yk_q;
  in_word_t               w_q;
  logic [ProdW-1:0]       m1_q, m2_q, rem_q, quo_q;
  logic [ValW:0]          dv_q;
  logic                   n1_q, n2_q, neg_q;
  logic [$clog2(ProdW+1)-1:0] cnt_q;
  out_word_t              res_q;

  // Captured word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) w_q <= in_word_i;
  end

  // Table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_x[w_q.point_index] <= w_q.x_value;
      mem_y[w_q.point_index] <= w_q.y_value;
    end
    if (cmd_i.rd_en) begin
      rx_q <= mem_x[cmd_i.rd_addr];
      ry_q <= mem_y[cmd_i.rd_addr];
    end
    if (cmd_i.keep_prev) begin
      xk_q <= rx_q;
      yk_q <= ry_q;
    end
  end

  // Compares on the query
  always_comb begin
    sts_o.below    = w_q.x_value < rx_q;
    sts_o.above    = w_q.x_value >= rx_q;
    sts_o.in_seg   = (w_q.x_value >= xk_q) && (w_q.x_value < rx_q);
    sts_o.div_done = (cnt_q == '0);
  end

  // Weights and magnitudes (33-bit differences)
  logic [ValW:0] w1, w2, ya_mag, yb_mag;
  always_comb begin
    w1 = ValW'(0) + ({rx_q[ValW-1], rx_q} - {w_q.x_value[ValW-1], w_q.x_value});
    w2 = {w_q.x_value[ValW-1], w_q.x_value} - {xk_q[ValW-1], xk_q};
    ya_mag = yk_q[ValW-1] ? -{1'b1, yk_q} : {1'b0, yk_q};
    yb_mag = ry_q[ValW-1] ? -{1'b1, ry_q} : {1'b0, ry_q};
  end

  // Multiply, combine, then shift-subtract divide one bit a cycle
  logic [ProdW:0] trial;
  always_comb trial = {rem_q, quo_q[ProdW-1]} - {{(ProdW-ValW){1'b0}}, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.sum) begin
      cnt_q <= ($clog2(ProdW+1))'(ProdW);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      m1_q <= ProdW'(ya_mag[ValW-1:0] * w1[ValW-1:0]);
      n1_q <= yk_q[ValW-1];
    end
    if (cmd_i.mul_b) begin
      m2_q <= ProdW'(yb_mag[ValW-1:0] * w2[ValW-1:0]);
      n2_q <= ry_q[ValW-1];
      dv_q <= {rx_q[ValW-1], rx_q} - {xk_q[ValW-1], xk_q};
    end
    if (cmd_i.sum) begin
      rem_q <= '0;
      if (n1_q == n2_q) begin
        quo_q <= m1_q + m2_q;
        neg_q <= n1_q;
      end else if (m1_q >= m2_q) begin
        quo_q <= m1_q - m2_q;
        neg_q <= n1_q;
      end else begin
        quo_q <= m2_q - m1_q;
        neg_q <= n2_q;
      end
    end else if (cmd_i.div_step && cnt_q != '0) begin
      if (!trial[ProdW]) begin
        rem_q <= trial[ProdW-1:0];
        quo_q <= {quo_q[ProdW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[ProdW-2:0], quo_q[ProdW-1]};
        quo_q <= {quo_q[ProdW-2:0], 1'b0};
      end
    end
  end

  // Result register
  logic [ProdW-1:0] sq;
  always_comb sq = neg_q ? -quo_q : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_clamp_lo) begin
      res_q <= '{y_out: ry_q, status: StClampLo};
    end else if (cmd_i.out_clamp_hi) begin
      res_q <= '{y_out: ry_q, status: StClampHi};
    end else if (cmd_i.out_zero) begin
      res_q <= '{y_out: '0, status: StZeroSeg};
    end else if (cmd_i.out_div) begin
      res_q <= '{y_out: sq[ValW-1:0], status: StInterp};
    end
  end
  assign res_o = res_q;

endmodule

// ----- sv/pli_ctrl.sv -----
// Controller: sequences load, clamp checks, segment search and divide.
module pli_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   in_opcode_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic [pli_pkg::CntW-1:0] npts_i,
  input  pli_pkg::pli_sts_t      sts_i,
  output pli_pkg::pli_cmd_t      cmd_o
);
  import pli_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_R0 = 4'd2, S_C0 = 4'd3,
                         S_CH = 4'd4, S_SRD = 4'd5, S_SCK = 4'd6, S_MB = 4'd7,
                         S_SUM = 4'd8, S_DIV = 4'd9, S_OUT = 4'd10, S_RH = 4'd11;

  logic [3:0]      st_q, st_d;
  logic [IdxW-1:0] k_q, k_d;
  logic            ov_q, ov_d;
  logic [IdxW-1:0] last;
  logic [CntW-1:0] n;

  always_comb begin
    n = npts_i;
    if (n < CntW'(2)) n = CntW'(2);
    if (n > CntW'(MaxPoints)) n = CntW'(MaxPoints);
    last = IdxW'(n - 1'b1);
  end

  // hold the input off while busy or while a result word is still waiting
  assign in_stall_o  = (st_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;

  always_comb begin
    st_d  = st_q;
    k_d   = k_q;
    ov_d  = ov_q && out_stall_i;
    cmd_o = '0;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i && !ov_q) begin
          cmd_o.capture = 1'b1;
          st_d = (in_opcode_i == OpLoad) ? S_LOAD : S_R0;
        end
      end
      S_LOAD: st_d = S_IDLE;
      S_R0: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = '0;
        st_d = S_C0;
      end
      S_C0: begin
        if (sts_i.below) begin
          cmd_o.out_clamp_lo = 1'b1;
          st_d = S_OUT;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = last;
          st_d = S_RH;
        end
      end
      S_RH: st_d = S_CH;
      S_CH: begin
        if (sts_i.above) begin
          cmd_o.out_clamp_hi = 1'b1;
          st_d = S_OUT;
        end else begin
          k_d = '0;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = '0;
          st_d = S_SRD;
        end
      end
      S_SRD: begin
        // read data holds slot k; keep it, fetch k+1
        cmd_o.keep_prev = 1'b1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_addr = k_q + 1'b1;
        st_d = S_SCK;
      end
      S_SCK: begin
        if (sts_i.in_seg) begin
          cmd_o.mul_a = 1'b1;
          st_d = S_MB;
        end else if (IdxW'(k_q + 1'b1) == last) begin
          cmd_o.out_zero = 1'b1;
          st_d = S_OUT;
        end else begin
          k_d = k_q + 1'b1;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_addr = k_q + 1'b1;
          st_d = S_SRD;
        end
      end
      S_MB: begin
        cmd_o.mul_b = 1'b1;
        st_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        st_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.div_step = 1'b0;
          cmd_o.out_div = 1'b1;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        ov_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    if (st_q == S_LOAD) cmd_o.load = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(st_q) == S_OUT) else $error("result out of sequence");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_OUT) |-> !ov_q) else $error("result overwritten");
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> in_stall_o) else $error("accept while result pending");
`endif

endmodule
